// File: rtl/stsm_pkg.sv
package stsm_pkg;

    // Audio and tone constants.
    localparam int SampleRateHz = 16000;
    localparam int SamplesPerMs = SampleRateHz / 1000;
    localparam int RampSamples  = 64;
    localparam int EffectCount  = 11;
    localparam int ToneLevel    = 5000;
    localparam int PctDiv       = 100;
    localparam int PctMax       = 100;

    // Datapath widths.
    localparam int MagW   = 16;
    localparam int GainW  = 7;
    localparam int ProdW  = MagW + GainW;
    localparam int RemW   = $clog2(PctDiv);
    localparam int FreqW  = 11;
    localparam int TotW   = 13;
    localparam int PhaseW = 14;
    localparam int PosW   = 3;
    localparam int FxW    = 4;
    localparam int RampW  = $clog2(RampSamples) + 1;
    localparam int AmpW   = 13;
    localparam int CfgIdxW = 2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgMusicGain  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgCryGain    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgEffectGain = 2'd2;

    // One note of an effect: tone frequency and length in samples.
    typedef struct packed {
        logic [FreqW-1:0] freq;
        logic [TotW-1:0]  total;
    } t_note;

    // Step controls for the serial percent-scaling lanes.
    typedef struct packed {
        logic load;
        logic mul;
        logic div_init;
        logic div;
    } t_lane_ctl;

    function automatic t_note mk_note(input int freq, input int ms);
        t_note n;
        n.freq  = FreqW'(freq);
        n.total = TotW'(ms * SamplesPerMs);
        return n;
    endfunction

    // Number of notes in each effect; unused slots are empty.
    function automatic logic [PosW-1:0] tone_len(input logic [FxW-1:0] slot);
        logic [PosW-1:0] len;
        case (slot)
            4'd0:    len = 3'd1;
            4'd1:    len = 3'd3;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd2;
            4'd4:    len = 3'd4;
            4'd5:    len = 3'd5;
            4'd6:    len = 3'd5;
            4'd7:    len = 3'd2;
            4'd8:    len = 3'd3;
            4'd9:    len = 3'd2;
            4'd10:   len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Note table: frequency in Hz and duration in ms. Frequency zero is a rest.
    function automatic t_note tone_note(input logic [FxW-1:0] slot,
                                        input logic [PosW-1:0] pos);
        t_note n;
        n = mk_note(0, 0);
        case (slot)
            4'd0: begin
                case (pos)
                    3'd0:    n = mk_note(880, 35);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd1: begin
                case (pos)
                    3'd0:    n = mk_note(660, 45);
                    3'd1:    n = mk_note(0, 12);
                    3'd2:    n = mk_note(660, 45);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd2: begin
                case (pos)
                    3'd0:    n = mk_note(784, 45);
                    3'd1:    n = mk_note(988, 60);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd3: begin
                case (pos)
                    3'd0:    n = mk_note(1047, 55);
                    3'd1:    n = mk_note(1319, 90);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd4: begin
                case (pos)
                    3'd0:    n = mk_note(523, 80);
                    3'd1:    n = mk_note(659, 80);
                    3'd2:    n = mk_note(784, 110);
                    3'd3:    n = mk_note(1047, 170);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd5: begin
                case (pos)
                    3'd0:    n = mk_note(523, 80);
                    3'd1:    n = mk_note(659, 80);
                    3'd2:    n = mk_note(784, 80);
                    3'd3:    n = mk_note(1047, 90);
                    3'd4:    n = mk_note(1319, 230);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd6: begin
                case (pos)
                    3'd0:    n = mk_note(784, 70);
                    3'd1:    n = mk_note(0, 25);
                    3'd2:    n = mk_note(784, 70);
                    3'd3:    n = mk_note(0, 25);
                    3'd4:    n = mk_note(1047, 200);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd7: begin
                case (pos)
                    3'd0:    n = mk_note(300, 110);
                    3'd1:    n = mk_note(200, 170);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd8: begin
                case (pos)
                    3'd0:    n = mk_note(784, 150);
                    3'd1:    n = mk_note(659, 150);
                    3'd2:    n = mk_note(523, 280);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd9: begin
                case (pos)
                    3'd0:    n = mk_note(784, 70);
                    3'd1:    n = mk_note(1047, 130);
                    default: n = mk_note(0, 0);
                endcase
            end
            4'd10: begin
                case (pos)
                    3'd0:    n = mk_note(1175, 90);
                    3'd1:    n = mk_note(880, 110);
                    3'd2:    n = mk_note(0, 70);
                    3'd3:    n = mk_note(1175, 90);
                    3'd4:    n = mk_note(880, 150);
                    default: n = mk_note(0, 0);
                endcase
            end
            default: n = mk_note(0, 0);
        endcase
        return n;
    endfunction

endpackage

// File: rtl/stsm_lane.sv
// Serial percent scaler: quot = floor(mag * gain / 100).
// The multiply takes one gain bit per cycle, MSB first; the divide by 100
// is restoring division producing one quotient bit per cycle.
module stsm_lane import stsm_pkg::*; (
    input  logic             i_clk,
    input  t_lane_ctl        i_ctl,
    input  logic [MagW-1:0]  i_mag,
    input  logic [GainW-1:0] i_gain,
    output logic [MagW-1:0]  o_quot
);

    logic [MagW-1:0]  r_mag;
    logic [GainW-1:0] r_gain;
    logic [ProdW-1:0] r_prod;
    logic [RemW-1:0]  r_rem;
    logic [MagW-1:0]  r_quot;
    logic [RemW:0]    trial;
    logic             fits;

    // Partial remainder with the next dividend bit brought in.
    assign trial = {r_rem, r_prod[ProdW-1]};
    assign fits  = (trial >= (RemW+1)'(PctDiv));

    // Multiply, then divide, sharing the product shift register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag  <= i_mag;
            r_gain <= i_gain;
            r_prod <= '0;
            r_quot <= '0;
        end else if (i_ctl.mul) begin
            r_prod <= {r_prod[ProdW-2:0], 1'b0}
                      + (r_gain[GainW-1] ? ProdW'(r_mag) : ProdW'(0));
            r_gain <= {r_gain[GainW-2:0], 1'b0};
        end else if (i_ctl.div_init) begin
            // The top bits are already below 100, so they seed the remainder.
            r_rem  <= RemW'(r_prod[ProdW-1:MagW]);
            r_prod <= r_prod << GainW;
        end else if (i_ctl.div) begin
            r_rem  <= fits ? RemW'(trial - (RemW+1)'(PctDiv)) : RemW'(trial);
            r_prod <= {r_prod[ProdW-2:0], 1'b0};
            r_quot <= {r_quot[MagW-2:0], fits};
        end
    end

    assign o_quot = r_quot;

endmodule

// File: rtl/stsm_tone.sv
// Effect player: note sequencer, phase accumulator, ramp and square level.
// State advances once per sample on i_step.
module stsm_tone import stsm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_start,
    input  logic [FxW-1:0]  i_num,
    input  logic            i_audible,
    output logic [AmpW-1:0] o_amp,
    output logic            o_neg,
    output logic            o_busy
);

    localparam int RampShift = $clog2(RampSamples);
    localparam int ScaledW   = AmpW + RampShift;

    logic              r_playing;
    logic [FxW-1:0]    r_fx;
    logic [PosW-1:0]   r_pos;
    logic [TotW-1:0]   r_cnt;
    logic [PhaseW-1:0] r_phase;
    logic [AmpW-1:0]   r_amp;
    logic              r_neg;

    logic              n_playing;
    logic [FxW-1:0]    n_fx;
    logic [PosW-1:0]   n_pos;
    logic [TotW-1:0]   n_cnt;
    logic [PhaseW-1:0] n_phase;
    logic [AmpW-1:0]   n_amp;
    logic              n_neg;

    logic              start_ok;
    logic              s_playing;
    logic [FxW-1:0]    s_fx;
    logic [PosW-1:0]   s_pos;
    logic [TotW-1:0]   s_cnt;
    logic [PhaseW-1:0] s_phase;
    t_note             note;
    logic [PosW-1:0]   len;
    logic [PhaseW:0]   ph_sum;
    logic [PhaseW-1:0] ph_next;
    logic [TotW-1:0]   rem;
    logic [RampW-1:0]  ramp;
    logic [ScaledW-1:0] scaled;
    logic [TotW-1:0]   cnt_inc;
    logic [PosW:0]     pos_inc;

    // A start of a known effect rewinds the player before this sample.
    assign start_ok = i_start && (i_num < FxW'(EffectCount)) && (tone_len(i_num) != '0);

    always_comb begin
        s_playing = r_playing;
        s_fx      = r_fx;
        s_pos     = r_pos;
        s_cnt     = r_cnt;
        s_phase   = r_phase;
        if (start_ok) begin
            s_playing = 1'b1;
            s_fx      = i_num;
            s_pos     = '0;
            s_cnt     = '0;
            s_phase   = '0;
        end
    end

    // Current note, phase step and ramp level.
    assign note    = tone_note(s_fx, s_pos);
    assign len     = tone_len(s_fx);
    assign ph_sum  = {1'b0, s_phase} + (PhaseW+1)'(note.freq);
    assign ph_next = (ph_sum >= (PhaseW+1)'(SampleRateHz))
                     ? PhaseW'(ph_sum - (PhaseW+1)'(SampleRateHz)) : PhaseW'(ph_sum);
    assign rem     = (note.total > s_cnt) ? (note.total - s_cnt) : '0;
    assign cnt_inc = s_cnt + TotW'(1);
    assign pos_inc = {1'b0, s_pos} + (PosW+1)'(1);

    always_comb begin
        if (s_cnt < TotW'(RampSamples)) begin
            ramp = RampW'(s_cnt);
        end else if (rem < TotW'(RampSamples)) begin
            ramp = RampW'(rem);
        end else begin
            ramp = RampW'(RampSamples);
        end
    end

    assign scaled = ScaledW'(ramp) * ScaledW'(ToneLevel);

    // Next player state and the unsigned tone level for this sample.
    always_comb begin
        n_playing = s_playing;
        n_fx      = s_fx;
        n_pos     = s_pos;
        n_cnt     = s_cnt;
        n_phase   = s_phase;
        n_amp     = '0;
        n_neg     = 1'b0;
        if (!i_audible) begin
            n_playing = 1'b0;
        end else if (s_playing) begin
            if (s_pos >= len) begin
                n_playing = 1'b0;
            end else begin
                if (note.freq != '0) begin
                    n_amp   = scaled[ScaledW-1:RampShift];
                    n_neg   = (ph_next >= PhaseW'(SampleRateHz / 2));
                    n_phase = ph_next;
                end
                if (cnt_inc >= note.total) begin
                    n_cnt   = '0;
                    n_phase = '0;
                    if (pos_inc >= {1'b0, len}) begin
                        n_playing = 1'b0;
                        n_pos     = '0;
                    end else begin
                        n_pos = pos_inc[PosW-1:0];
                    end
                end else begin
                    n_cnt = cnt_inc;
                end
            end
        end
    end

    // Player state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_fx      <= '0;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_phase   <= '0;
        end else if (i_step) begin
            r_playing <= n_playing;
            r_fx      <= n_fx;
            r_pos     <= n_pos;
            r_cnt     <= n_cnt;
            r_phase   <= n_phase;
        end
    end

    // Tone level and sign for the scaling lane.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_amp <= n_amp;
            r_neg <= n_neg;
        end
    end

    assign o_amp  = r_amp;
    assign o_neg  = r_neg;
    assign o_busy = r_playing;

endmodule

// File: rtl/square_tone_sfx_mixer.sv
// Channel   Handshake          Payload
// input     i_valid/o_ready    start, effect number, audible, music, cry
// output    o_valid/i_ready    mixed sample, effect busy
// config    i_cfg_we           i_cfg_idx, i_cfg_data (no wait)
//
// Each sample runs from its input transfer through the tone player step, the lane
// load, the serial multiply (one gain bit per step), the serial divide by 100,
// the mix into the output register and an idle state with ready high; only
// then can the next input transfer take place.
// Reset (synchronous, active low) restores the default gains and stops any effect.
// A result waiting in the output register stalls only the final mix step.
module square_tone_sfx_mixer import stsm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_start_effect,
    input  logic [FxW-1:0]         i_effect_number,
    input  logic                   i_audible,
    input  logic                   i_music_valid,
    input  logic signed [MagW-1:0] i_music_sample,
    input  logic                   i_cry_valid,
    input  logic signed [MagW-1:0] i_cry_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [MagW-1:0] o_mixed_sample,
    output logic                   o_effect_busy,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxW-1:0]     i_cfg_idx,
    input  logic [GainW-1:0]       i_cfg_data
);

    localparam int StW  = 3;
    localparam int CntW = $clog2(MagW);
    localparam int SumW = MagW + 2;

    localparam logic [StW-1:0] S_IDLE = 3'd0;
    localparam logic [StW-1:0] S_PREP = 3'd1;
    localparam logic [StW-1:0] S_LOAD = 3'd2;
    localparam logic [StW-1:0] S_MUL  = 3'd3;
    localparam logic [StW-1:0] S_DIVI = 3'd4;
    localparam logic [StW-1:0] S_DIV  = 3'd5;
    localparam logic [StW-1:0] S_DONE = 3'd6;

    localparam logic [CntW-1:0] MulLast = CntW'(GainW - 1);
    localparam logic [CntW-1:0] DivLast = CntW'(MagW - 1);

    logic [StW-1:0]   r_state;
    logic [StW-1:0]   n_state;
    logic [CntW-1:0]  r_cnt;
    logic [CntW-1:0]  n_cnt;

    logic [GainW-1:0] r_music_gain;
    logic [GainW-1:0] r_cry_gain;
    logic [GainW-1:0] r_effect_gain;
    logic [GainW-1:0] cfg_gain;

    logic             r_start;
    logic [FxW-1:0]   r_num;
    logic             r_audible;
    logic             r_mvalid;
    logic [MagW-1:0]  r_msample;
    logic             r_cvalid;
    logic [MagW-1:0]  r_csample;
    logic             r_mus_neg;
    logic             r_cry_neg;

    logic             r_out_valid;
    logic [MagW-1:0]  r_out_sample;
    logic             r_out_busy;

    logic             in_xfer;
    logic             out_load;
    t_lane_ctl        lane_ctl;
    logic [MagW-1:0]  mus_mag;
    logic [MagW-1:0]  cry_mag;
    logic [MagW-1:0]  fx_mag;
    logic [MagW-1:0]  mus_quot;
    logic [MagW-1:0]  cry_quot;
    logic [MagW-1:0]  fx_quot;
    logic [AmpW-1:0]  tone_amp;
    logic             tone_neg;
    logic             tone_busy;
    logic signed [SumW-1:0] sum;
    logic [MagW-1:0]  sat;

    function automatic logic signed [SumW-1:0] signed_term(input logic [MagW-1:0] q,
                                                           input logic neg);
        logic signed [SumW-1:0] t;
        t = $signed({2'b00, q});
        return neg ? -t : t;
    endfunction

    assign in_xfer  = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // Gain registers; writes above 100 percent clamp to 100.
    assign cfg_gain = (i_cfg_data > GainW'(PctMax)) ? GainW'(PctMax) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_music_gain  <= GainW'(25);
            r_cry_gain    <= GainW'(65);
            r_effect_gain <= GainW'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgMusicGain:  r_music_gain  <= cfg_gain;
                CfgCryGain:    r_cry_gain    <= cfg_gain;
                CfgEffectGain: r_effect_gain <= cfg_gain;
                default:       ;
            endcase
        end
    end

    // Sequencer: player step, lane load, serial multiply, serial divide, mix.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_MUL;
                n_cnt   = '0;
            end
            S_MUL: begin
                if (r_cnt == MulLast) begin
                    n_state = S_DIVI;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            S_DIVI: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == DivLast) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // Capture the input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_start   <= i_start_effect;
            r_num     <= i_effect_number;
            r_audible <= i_audible;
            r_mvalid  <= i_music_valid;
            r_msample <= i_music_sample;
            r_cvalid  <= i_cry_valid;
            r_csample <= i_cry_sample;
        end
    end

    // Effect player.
    stsm_tone u_tone (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (r_state == S_PREP),
        .i_start   (r_start),
        .i_num     (r_num),
        .i_audible (r_audible),
        .o_amp     (tone_amp),
        .o_neg     (tone_neg),
        .o_busy    (tone_busy)
    );

    // Lane operands: magnitudes, zero for a muted or absent source.
    assign mus_mag = (r_audible && r_mvalid)
                     ? (r_msample[MagW-1] ? (~r_msample + MagW'(1)) : r_msample) : '0;
    assign cry_mag = (r_audible && r_cvalid)
                     ? (r_csample[MagW-1] ? (~r_csample + MagW'(1)) : r_csample) : '0;
    assign fx_mag  = MagW'(tone_amp);

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_mus_neg <= r_msample[MagW-1];
            r_cry_neg <= r_csample[MagW-1];
        end
    end

    assign lane_ctl.load     = (r_state == S_LOAD);
    assign lane_ctl.mul      = (r_state == S_MUL);
    assign lane_ctl.div_init = (r_state == S_DIVI);
    assign lane_ctl.div      = (r_state == S_DIV);

    stsm_lane u_lane_music (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_mag  (mus_mag),
        .i_gain (r_music_gain),
        .o_quot (mus_quot)
    );

    stsm_lane u_lane_cry (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_mag  (cry_mag),
        .i_gain (r_cry_gain),
        .o_quot (cry_quot)
    );

    stsm_lane u_lane_fx (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_mag  (fx_mag),
        .i_gain (r_effect_gain),
        .o_quot (fx_quot)
    );

    // Mix the signed terms and saturate to 16 bits.
    assign sum = signed_term(mus_quot, r_mus_neg)
               + signed_term(cry_quot, r_cry_neg)
               + signed_term(fx_quot, tone_neg);

    always_comb begin
        if (sum > SumW'(32767)) begin
            sat = 16'h7FFF;
        end else if (sum < -SumW'(32768)) begin
            sat = 16'h8000;
        end else begin
            sat = sum[MagW-1:0];
        end
    end

    // Output register; holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= sat;
            r_out_busy   <= tone_busy;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mixed_sample = r_out_sample;
    assign o_effect_busy  = r_out_busy;

endmodule

// File: bench/square_tone_sfx_mixer_tb.sv
module square_tone_sfx_mixer_tb;
    import stsm_pkg::*;

    localparam int NotesMax     = 5;
    localparam int StallCycles  = 300;
    localparam int DrainCycles  = 64;
    localparam int MaxReports   = 10;
    localparam int TimeoutTicks = 8000000;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    // One input tick and one mixed output sample.
    typedef struct packed {
        logic                   start;
        logic [FxW-1:0]         num;
        logic                   audible;
        logic                   mvalid;
        logic signed [MagW-1:0] msample;
        logic                   cvalid;
        logic signed [MagW-1:0] csample;
    } t_tick;

    typedef struct packed {
        logic signed [MagW-1:0] mixed;
        logic                   busy;
    } t_mix;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_start_effect = 1'b0;
    logic [FxW-1:0]         i_effect_number = '0;
    logic                   i_audible = 1'b0;
    logic                   i_music_valid = 1'b0;
    logic signed [MagW-1:0] i_music_sample = '0;
    logic                   i_cry_valid = 1'b0;
    logic signed [MagW-1:0] i_cry_sample = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic signed [MagW-1:0] o_mixed_sample;
    logic                   o_effect_busy;
    logic                   i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]     i_cfg_idx = '0;
    logic [GainW-1:0]       i_cfg_data = '0;

    square_tone_sfx_mixer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_start_effect  (i_start_effect),
        .i_effect_number (i_effect_number),
        .i_audible       (i_audible),
        .i_music_valid   (i_music_valid),
        .i_music_sample  (i_music_sample),
        .i_cry_valid     (i_cry_valid),
        .i_cry_sample    (i_cry_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_mixed_sample  (o_mixed_sample),
        .o_effect_busy   (o_effect_busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // Effect note table, flattened as effect * NotesMax + note.
    int fx_hz [EffectCount*NotesMax] = '{
        880,  0,    0,    0,    0,
        660,  0,    660,  0,    0,
        784,  988,  0,    0,    0,
        1047, 1319, 0,    0,    0,
        523,  659,  784,  1047, 0,
        523,  659,  784,  1047, 1319,
        784,  0,    784,  0,    1047,
        300,  200,  0,    0,    0,
        784,  659,  523,  0,    0,
        784,  1047, 0,    0,    0,
        1175, 880,  0,    1175, 880
    };
    int fx_ms [EffectCount*NotesMax] = '{
        35,  0,   0,   0,   0,
        45,  12,  45,  0,   0,
        45,  60,  0,   0,   0,
        55,  90,  0,   0,   0,
        80,  80,  110, 170, 0,
        80,  80,  80,  90,  230,
        70,  25,  70,  25,  200,
        110, 170, 0,   0,   0,
        150, 150, 280, 0,   0,
        70,  130, 0,   0,   0,
        90,  110, 70,  90,  150
    };
    int fx_len [EffectCount] = '{1, 3, 2, 2, 4, 5, 5, 2, 3, 2, 5};

    // Mirror of the block state and its gain registers.
    logic [GainW-1:0]  g_music = 7'd25;
    logic [GainW-1:0]  g_cry = 7'd65;
    logic [GainW-1:0]  g_fx = 7'd100;
    logic              fx_on = 1'b0;
    logic [FxW-1:0]    fx_id = '0;
    logic [PosW-1:0]   fx_note = '0;
    logic [TotW-1:0]   fx_count = '0;
    logic [PhaseW-1:0] fx_phase = '0;

    t_tick tick_q [$];
    t_mix  mix_q [$];
    t_tick cur_tick;

    int send_idle = 30;
    int recv_idle = 50;
    int stall_req = 0;
    int stall_ack = 0;
    int stall_left = 0;
    int errors = 0;
    int ticks_sent = 0;
    int notes_done = 0;
    int effects_done = 0;
    int gain_sets = 0;

    // Next tone sample of the running effect, advancing the note player.
    function automatic int tone_step();
        int idx;
        int hz;
        int total;
        int rem;
        int ramp;
        int v;
        v = 0;
        if (fx_note >= fx_len[fx_id]) begin
            fx_on = 1'b0;
            return 0;
        end
        idx   = fx_id * NotesMax + fx_note;
        hz    = fx_hz[idx];
        total = fx_ms[idx] * SamplesPerMs;
        if (hz != 0) begin
            fx_phase = PhaseW'((fx_phase + hz) % SampleRateHz);
            rem = (total > fx_count) ? total - fx_count : 0;
            if (fx_count < RampSamples) begin
                ramp = int'(fx_count);
            end else if (rem < RampSamples) begin
                ramp = rem;
            end else begin
                ramp = RampSamples;
            end
            v = ToneLevel * ramp / RampSamples * int'(g_fx) / PctDiv;
            if (fx_phase >= SampleRateHz / 2) begin
                v = -v;
            end
        end
        fx_count = fx_count + 1'b1;
        if (fx_count >= total) begin
            fx_count = '0;
            fx_phase = '0;
            fx_note  = fx_note + 1'b1;
            notes_done++;
            if (fx_note >= fx_len[fx_id]) begin
                fx_on   = 1'b0;
                fx_note = '0;
                effects_done++;
            end
        end
        return v;
    endfunction

    // Expected output for one accepted tick.
    function automatic t_mix mix_tick(input t_tick t);
        t_mix r;
        int   sum;
        int   m;
        int   c;
        sum = 0;
        m   = $signed(t.msample);
        c   = $signed(t.csample);
        if (t.start && t.num < EffectCount) begin
            fx_on    = 1'b1;
            fx_id    = t.num;
            fx_note  = '0;
            fx_count = '0;
            fx_phase = '0;
        end
        if (!t.audible) begin
            fx_on = 1'b0;
        end else begin
            if (t.mvalid) begin
                sum += m * int'(g_music) / PctDiv;
            end
            if (t.cvalid) begin
                sum += c * int'(g_cry) / PctDiv;
            end
            if (fx_on) begin
                sum += tone_step();
            end
        end
        if (sum > 32767) begin
            sum = 32767;
        end
        if (sum < -32768) begin
            sum = -32768;
        end
        r.mixed = sum[MagW-1:0];
        r.busy  = fx_on;
        return r;
    endfunction

    // PCM value biased toward the extremes.
    function automatic logic [MagW-1:0] rand_pcm();
        case ($urandom_range(7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return MagW'($urandom);
        endcase
    endfunction

    // Audible tick with random music and cry content and no start.
    function automatic t_tick play_tick();
        t_tick t;
        t.start   = 1'b0;
        t.num     = FxW'($urandom);
        t.audible = 1'b1;
        t.mvalid  = 1'($urandom_range(1));
        t.msample = rand_pcm();
        t.cvalid  = 1'($urandom_range(1));
        t.csample = rand_pcm();
        return t;
    endfunction

    function automatic t_tick noise_tick();
        t_tick t;
        t = play_tick();
        t.start   = 1'($urandom_range(1));
        t.audible = 1'($urandom_range(1));
        return t;
    endfunction

    task automatic push_tick(input bit st, input int num, input bit aud, input bit mv,
                             input int ms, input bit cv, input int cs);
        t_tick t;
        t.start   = st;
        t.num     = FxW'(num);
        t.audible = aud;
        t.mvalid  = mv;
        t.msample = MagW'(ms);
        t.cvalid  = cv;
        t.csample = MagW'(cs);
        tick_q.push_back(t);
    endtask

    // Mostly short effect runs with random content, plus restarts, cancels and noise.
    task automatic random_ticks(input int count);
        int    n;
        int    kind;
        t_tick t;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(9);
            if (kind <= 5) begin
                t = play_tick();
                t.start = 1'b1;
                t.num   = FxW'($urandom_range(EffectCount - 1));
                tick_q.push_back(t);
                n++;
                repeat ($urandom_range(60, 5)) begin
                    tick_q.push_back(play_tick());
                    n++;
                end
            end else if (kind == 6) begin
                t = play_tick();
                t.start = 1'b1;
                tick_q.push_back(t);
                n++;
            end else if (kind == 7) begin
                repeat ($urandom_range(3, 1)) begin
                    t = noise_tick();
                    t.audible = 1'b0;
                    tick_q.push_back(t);
                    n++;
                end
            end else begin
                tick_q.push_back(noise_tick());
                n++;
            end
        end
    endtask

    // Plays one effect through every note to its end, with an ignored start halfway.
    task automatic play_through(input int fx);
        int    total;
        int    i;
        t_tick t;
        total = 0;
        for (i = 0; i < fx_len[fx]; i++) begin
            total += fx_ms[fx * NotesMax + i] * SamplesPerMs;
        end
        t = play_tick();
        t.start = 1'b1;
        t.num   = FxW'(fx);
        tick_q.push_back(t);
        for (i = 0; i < total + 8; i++) begin
            t = play_tick();
            if (i == total / 2) begin
                t.start = 1'b1;
                t.num   = FxW'(EffectCount + 2);
            end
            tick_q.push_back(t);
        end
    endtask

    task automatic write_gain(input logic [CfgIdxW-1:0] idx, input int value);
        logic [GainW-1:0] g;
        g = GainW'(value);
        if (g > PctMax) begin
            g = GainW'(PctMax);
        end
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= GainW'(value);
        case (idx)
            CfgMusicGain:  g_music = g;
            CfgCryGain:    g_cry   = g;
            CfgEffectGain: g_fx    = g;
            default: ;
        endcase
    endtask

    // Gain writes happen only with the block drained.
    task automatic set_gains(input int m, input int c, input int f);
        write_gain(CfgMusicGain, m);
        write_gain(CfgCryGain, c);
        write_gain(CfgEffectGain, f);
        write_gain(CfgUnused, $urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gain_sets++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        while (tick_q.size() != 0 || i_valid || mix_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TimeoutTicks);
        $display("simulation failed");
        $finish;
    end

    // Input driver: offers queued ticks and predicts each one on its transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                mix_q.push_back(mix_tick(cur_tick));
                ticks_sent++;
            end
            if (!i_valid || o_ready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    cur_tick = tick_q.pop_front();
                    i_valid         <= 1'b1;
                    i_start_effect  <= cur_tick.start;
                    i_effect_number <= cur_tick.num;
                    i_audible       <= cur_tick.audible;
                    i_music_valid   <= cur_tick.mvalid;
                    i_music_sample  <= cur_tick.msample;
                    i_cry_valid     <= cur_tick.cvalid;
                    i_cry_sample    <= cur_tick.csample;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (mix_q.size() == 0) begin
                    errors++;
                    if (errors <= MaxReports) begin
                        $display("unexpected output: sample %0d busy %0b",
                                 o_mixed_sample, o_effect_busy);
                    end
                end else begin
                    t_mix want;
                    want = mix_q.pop_front();
                    if (o_mixed_sample !== want.mixed || o_effect_busy !== want.busy) begin
                        errors++;
                        if (errors <= MaxReports) begin
                            $display("mismatch: expected sample %0d busy %0b, got %0d busy %0b",
                                     want.mixed, want.busy, o_mixed_sample, o_effect_busy);
                        end
                    end
                end
            end
            // A long output stall, counted here, lets the block back up its input.
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                i_ready <= 1'b0;
            end else if (stall_req != stall_ack) begin
                stall_ack++;
                stall_left = StallCycles;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks at full gain, with an over-range write that must clamp.
        set_gains(100, 127, 100);
        push_tick(0, 0, 1, 1, 32767, 1, 32767);
        push_tick(0, 0, 1, 1, -32768, 1, -32768);
        push_tick(0, 0, 1, 1, 32767, 0, -32768);
        push_tick(0, 0, 1, 0, -32768, 1, -1);
        push_tick(0, 0, 0, 1, 32767, 1, 32767);
        push_tick(1, 15, 1, 0, 0, 0, 0);
        push_tick(1, 11, 1, 0, 0, 0, 0);
        push_tick(1, 0, 1, 0, 0, 0, 0);
        repeat (4) push_tick(0, 0, 1, 0, 0, 0, 0);
        push_tick(1, 3, 1, 1, -5, 1, 7);
        push_tick(0, 0, 1, 0, 0, 0, 0);
        push_tick(0, 0, 1, 1, 1, 1, -1);
        push_tick(1, 12, 1, 0, 0, 0, 0);
        push_tick(1, 10, 0, 1, 100, 1, 100);
        push_tick(0, 0, 1, 0, 0, 0, 0);
        push_tick(1, 5, 1, 1, 32767, 1, 32767);
        push_tick(0, 0, 1, 1, 32767, 1, 32767);
        push_tick(0, 0, 0, 0, 0, 0, 0);
        push_tick(0, 0, 1, 1, -1, 1, 1);
        wait_drain();

        // Odd gains expose truncation; the first batch meets a long output stall.
        set_gains(33, 77, 51);
        stall_req++;
        random_ticks(60);
        play_through(0);
        random_ticks(100);
        wait_drain();

        // All gains at zero, with a full drain pause in the middle.
        set_gains(0, 0, 0);
        random_ticks(80);
        wait_drain();
        random_ticks(80);
        wait_drain();

        send_idle = 50;
        recv_idle = 30;
        set_gains(100, 100, 100);
        random_ticks(130);
        wait_drain();

        set_gains($urandom_range(127), $urandom_range(127), $urandom_range(127));
        random_ticks(130);
        wait_drain();

        send_idle = 0;
        recv_idle = 0;
        set_gains(25, 65, 100);
        random_ticks(130);
        wait_drain();

        set_gains($urandom_range(127), $urandom_range(127), $urandom_range(127));
        random_ticks(130);
        wait_drain();
        repeat (DrainCycles) @(posedge i_clk);

        $display("%0d ticks mixed under %0d gain settings, %0d mismatches",
                 ticks_sent, gain_sets, errors);
        $display("%0d notes and %0d effects played out, including restarts and cancels",
                 notes_done, effects_done);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/stsm_pkg.sv
rtl/stsm_lane.sv
rtl/stsm_tone.sv
rtl/square_tone_sfx_mixer.sv
bench/square_tone_sfx_mixer_tb.sv
